@@ rtl/sdjq_pkg.sv @@
// Package for the sorted deadline job queue.
// Holds operation and result codes, field widths and the control structs.
// Depends on nothing; used by every module under rtl.
`default_nettype none

package sdjq_pkg;

   localparam int TIME_W  = 32;
   localparam int ID_W    = 8;
   localparam int DELAY_W = 16;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 3;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERTED = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_REMOVED  = 3'd2,
      KIND_EMPTY    = 3'd3,
      KIND_RELEASED = 3'd4
   } kind_type;

   typedef struct packed {
      logic load;
      logic insert;
      logic pop;
      logic tick;
      logic release_head;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   head_due;
      logic   next_due;
      logic   slot_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/sdjq_ctrl.sv @@
// Controller of the sorted deadline job queue.
// Sequences accept, execute and release steps; uses sdjq_pkg.
`default_nettype none

module sdjq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sdjq_pkg::sts_type sts,
   output sdjq_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_EXEC    = 3'b010,
      ST_RELEASE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (sts.op)
               sdjq_pkg::OP_INSERT: begin
                  if (sts.slot_free) begin
                     cmd.insert = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               sdjq_pkg::OP_POP: begin
                  if (sts.slot_free) begin
                     cmd.pop  = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               sdjq_pkg::OP_TICK: begin
                  cmd.tick = 1'b1;
                  state_in = ST_RELEASE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_RELEASE: begin
            if (!sts.head_due) begin
               state_in = ST_IDLE;
            end else if (sts.slot_free) begin
               cmd.release_head = 1'b1;
               if (!sts.next_due) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sdjq_datapath.sv @@
// Datapath of the sorted deadline job queue: time counter, sorted cell
// array with shift insert and shift remove, and the result register.
// Uses sdjq_pkg; driven by sdjq_ctrl.
`default_nettype none

module sdjq_datapath #(
   parameter int DEPTH = 16,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sdjq_pkg::cmd_type             cmd,
   output sdjq_pkg::sts_type                  sts,
   input  wire logic [sdjq_pkg::OP_W-1:0]     req_operation,
   input  wire logic [sdjq_pkg::ID_W-1:0]     req_job_id,
   input  wire logic [sdjq_pkg::DELAY_W-1:0]  req_delay,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sdjq_pkg::KIND_W-1:0]        rsp_kind,
   output logic [sdjq_pkg::ID_W-1:0]          rsp_out_job_id,
   output logic [sdjq_pkg::TIME_W-1:0]        rsp_out_due_time,
   output logic [CNT_W-1:0]                   rsp_occupancy,
   output logic                               rsp_last
);

   localparam int TW = sdjq_pkg::TIME_W;
   localparam int IW = sdjq_pkg::ID_W;

   logic [TW-1:0]      now_ff, now_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   sdjq_pkg::op_type   op_ff;
   logic [IW-1:0]      id_ff;
   logic [TW-1:0]      due_ff;
   logic [TW:0]        due_sum;
   logic [TW-1:0]      due_sat;

   logic [TW-1:0]      cell_due_ff [DEPTH];
   logic [TW-1:0]      cell_due_in [DEPTH];
   logic [IW-1:0]      cell_id_ff  [DEPTH];
   logic [IW-1:0]      cell_id_in  [DEPTH];

   logic [DEPTH-1:0]   keep;
   logic               front;
   logic               full;
   logic               empty;
   logic               shift_down;
   logic               do_insert;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sdjq_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]                rsp_id_ff, rsp_id_in;
   logic [TW-1:0]                rsp_due_ff, rsp_due_in;
   logic [CNT_W-1:0]             rsp_occ_ff, rsp_occ_in;
   logic                         rsp_last_ff, rsp_last_in;

   assign due_sum = {1'b0, now_ff} + {{(TW + 1 - sdjq_pkg::DELAY_W){1'b0}}, req_delay};
   assign due_sat = due_sum[TW] ? sdjq_pkg::TIME_MAX : due_sum[TW-1:0];

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign front = empty || (due_ff <= cell_due_ff[0]);

   for (genvar i = 0; i < DEPTH; i++) begin : g_keep
      assign keep[i] = (CNT_W'(i) < count_ff) && (cell_due_ff[i] <= due_ff) && !front;
   end

   assign do_insert  = cmd.insert && !full;
   assign shift_down = (cmd.pop && !empty) || cmd.release_head;

   assign sts.op        = op_ff;
   assign sts.head_due  = !empty && (cell_due_ff[0] <= now_ff);
   assign sts.next_due  = (count_ff > CNT_W'(1)) && (cell_due_ff[1] <= now_ff);
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cell_due_in = cell_due_ff;
      cell_id_in  = cell_id_ff;
      if (do_insert) begin
         if (!keep[0]) begin
            cell_due_in[0] = due_ff;
            cell_id_in[0]  = id_ff;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (!keep[i]) begin
               if (keep[i-1]) begin
                  cell_due_in[i] = due_ff;
                  cell_id_in[i]  = id_ff;
               end else begin
                  cell_due_in[i] = cell_due_ff[i-1];
                  cell_id_in[i]  = cell_id_ff[i-1];
               end
            end
         end
      end else if (shift_down) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            cell_due_in[i] = cell_due_ff[i+1];
            cell_id_in[i]  = cell_id_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (shift_down) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      now_in = now_ff;
      if (cmd.tick && (now_ff != sdjq_pkg::TIME_MAX)) begin
         now_in = now_ff + TW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.insert) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = full ? sdjq_pkg::KIND_REJECTED : sdjq_pkg::KIND_INSERTED;
         rsp_id_in    = id_ff;
         rsp_due_in   = due_ff;
         rsp_occ_in   = count_in;
         rsp_last_in  = 1'b1;
      end else if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = empty ? sdjq_pkg::KIND_EMPTY : sdjq_pkg::KIND_REMOVED;
         rsp_id_in    = empty ? '0 : cell_id_ff[0];
         rsp_due_in   = empty ? '0 : cell_due_ff[0];
         rsp_occ_in   = count_in;
         rsp_last_in  = 1'b1;
      end else if (cmd.release_head) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = sdjq_pkg::KIND_RELEASED;
         rsp_id_in    = cell_id_ff[0];
         rsp_due_in   = cell_due_ff[0];
         rsp_occ_in   = count_in;
         rsp_last_in  = !sts.next_due;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= sdjq_pkg::OP_NONE;
      end else begin
         now_ff       <= now_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            op_ff <= sdjq_pkg::op_type'(req_operation);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff  <= req_job_id;
         due_ff <= due_sat;
      end
      cell_due_ff <= cell_due_in;
      cell_id_ff  <= cell_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_due_ff  <= rsp_due_in;
      rsp_occ_ff  <= rsp_occ_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_job_id   = rsp_id_ff;
   assign rsp_out_due_time = rsp_due_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Queue count exceeds its depth.");

   a_release_due: assert property (@(posedge clock) disable iff (reset)
      cmd.release_head |-> (sts.head_due && sts.slot_free))
      else $error("A job was released before it was due or into a busy slot.");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("An accepted insert did not grow the queue.");

   a_release_time: assert property (@(posedge clock) disable iff (reset)
      cmd.release_head |=> (rsp_valid_ff && (rsp_due_ff <= now_ff)))
      else $error("A released beat carries a due time later than the counter.");
`endif

endmodule

`default_nettype wire

@@ rtl/sorted_deadline_job_queue.sv @@
// Top level of the sorted deadline job queue.
// Joins sdjq_ctrl and sdjq_datapath; uses sdjq_pkg.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_operation, req_job_id, req_delay
//   rsp_      out         rsp_valid/rsp_ready    rsp_kind, rsp_out_job_id,
//                                                rsp_out_due_time, rsp_occupancy, rsp_last
//
// Insert and pop have two steps: accept the request and form the due time, then
// place or remove the job in the shifting cell array and load the result register.
// A tick accepts, advances the time counter and then releases every job that has
// fallen due from the head of the queue, one beat per job.
// A full result register stalls the insert or pop execute step, or a release step, until it is taken.
// Reset empties the queue and clears the time counter.
`default_nettype none

module sorted_deadline_job_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sdjq_pkg::OP_W-1:0]         req_operation,
   input  wire logic [sdjq_pkg::ID_W-1:0]         req_job_id,
   input  wire logic [sdjq_pkg::DELAY_W-1:0]      req_delay,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [sdjq_pkg::KIND_W-1:0]            rsp_kind,
   output logic [sdjq_pkg::ID_W-1:0]              rsp_out_job_id,
   output logic [sdjq_pkg::TIME_W-1:0]            rsp_out_due_time,
   output logic [$clog2(DEPTH + 1)-1:0]           rsp_occupancy,
   output logic                                   rsp_last
);

   sdjq_pkg::cmd_type cmd;
   sdjq_pkg::sts_type sts;

   sdjq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdjq_datapath #(
      .DEPTH (DEPTH),
      .CNT_W ($clog2(DEPTH + 1))
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_job_id       (req_job_id),
      .req_delay        (req_delay),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_job_id   (rsp_out_job_id),
      .rsp_out_due_time (rsp_out_due_time),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

@@ tb/tb_sorted_deadline_job_queue.sv @@
// Self-checking testbench for the sorted deadline job queue, driven through its
// req_ and rsp_ ports. A scoreboard class keeps its own sorted queue and time counter,
// predicts every result beat and checks the beats as they leave. Depends on sdjq_pkg.
`default_nettype none

module tb_sorted_deadline_job_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 16;
   localparam int OCC_W        = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 280;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int TAIL_CYCLES  = 40;
   localparam int ID_W         = sdjq_pkg::ID_W;
   localparam int TIME_W       = sdjq_pkg::TIME_W;
   localparam int OP_W         = sdjq_pkg::OP_W;
   localparam int DELAY_W      = sdjq_pkg::DELAY_W;
   localparam int KIND_W       = sdjq_pkg::KIND_W;

   typedef struct packed {
      sdjq_pkg::kind_type kind;
      logic [ID_W-1:0]    job_id;
      logic [TIME_W-1:0]  due;
      logic [OCC_W-1:0]   occupancy;
      logic               last;
   } result_beat_type;

   class deadline_scoreboard_type;
      logic [TIME_W-1:0] slot_due [DEPTH];
      logic [ID_W-1:0]   slot_id [DEPTH];
      int                held;
      logic [TIME_W-1:0] now_ticks;
      result_beat_type   outcome_fifo [$];
      int                errors;

      function new();
         held      = 0;
         now_ticks = '0;
         errors    = 0;
      endfunction

      function int pending();
         return outcome_fifo.size();
      endfunction

      function void push_beat(sdjq_pkg::kind_type kind, logic [ID_W-1:0] job_id,
                              logic [TIME_W-1:0] due, int occ, logic last);
         result_beat_type beat;
         beat.kind      = kind;
         beat.job_id    = job_id;
         beat.due       = due;
         beat.occupancy = OCC_W'(occ);
         beat.last      = last;
         outcome_fifo.push_back(beat);
      endfunction

      function void apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] job_id,
                                  logic [DELAY_W-1:0] delay);
         logic [TIME_W:0]   sum;
         logic [TIME_W-1:0] due;
         int                pos;
         int                n;
         int                i;
         sum = {1'b0, now_ticks} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
         due = sum[TIME_W] ? sdjq_pkg::TIME_MAX : sum[TIME_W-1:0];
         case (op)
            sdjq_pkg::OP_INSERT: begin
               if (held >= DEPTH) begin
                  push_beat(sdjq_pkg::KIND_REJECTED, job_id, due, held, 1'b1);
               end else begin
                  pos = 0;
                  if (held != 0 && due > slot_due[0]) begin
                     while (pos < held && slot_due[pos] <= due) pos++;
                  end
                  for (i = held; i > pos; i--) begin
                     slot_due[i] = slot_due[i-1];
                     slot_id[i]  = slot_id[i-1];
                  end
                  slot_due[pos] = due;
                  slot_id[pos]  = job_id;
                  held++;
                  push_beat(sdjq_pkg::KIND_INSERTED, job_id, due, held, 1'b1);
               end
            end
            sdjq_pkg::OP_POP: begin
               if (held == 0) begin
                  push_beat(sdjq_pkg::KIND_EMPTY, '0, '0, 0, 1'b1);
               end else begin
                  push_beat(sdjq_pkg::KIND_REMOVED, slot_id[0], slot_due[0], held - 1,
                            1'b1);
                  for (i = 1; i < held; i++) begin
                     slot_due[i-1] = slot_due[i];
                     slot_id[i-1]  = slot_id[i];
                  end
                  held--;
               end
            end
            sdjq_pkg::OP_TICK: begin
               if (now_ticks != sdjq_pkg::TIME_MAX) now_ticks++;
               n = 0;
               while (n < held && slot_due[n] <= now_ticks) n++;
               for (i = 0; i < n; i++) begin
                  push_beat(sdjq_pkg::KIND_RELEASED, slot_id[i], slot_due[i], held - i - 1,
                            i == n - 1);
               end
               for (i = n; i < held; i++) begin
                  slot_due[i-n] = slot_due[i];
                  slot_id[i-n]  = slot_id[i];
               end
               held -= n;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_outcome(result_beat_type got);
         result_beat_type want;
         if (outcome_fifo.size() == 0) begin
            $error("result beat with none predicted: kind %0d job_id %0d",
                   got.kind, got.job_id);
            errors++;
         end else begin
            want = outcome_fifo.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, got.kind);
               errors++;
            end
            if (got.job_id !== want.job_id) begin
               $error("out_job_id: expected %0d, got %0d", want.job_id, got.job_id);
               errors++;
            end
            if (got.due !== want.due) begin
               $error("out_due_time: expected %0d, got %0d", want.due, got.due);
               errors++;
            end
            if (got.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
               errors++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = sdjq_pkg::OP_NONE;
   logic [ID_W-1:0]     req_job_id = '0;
   logic [DELAY_W-1:0]  req_delay = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [ID_W-1:0]     rsp_out_job_id;
   logic [TIME_W-1:0]   rsp_out_due_time;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                rsp_last;

   deadline_scoreboard_type scoreboard = new();
   int                      send_run = 0;
   int                      result_run = 0;
   int                      cycle_count = 0;

   sorted_deadline_job_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_job_id       (req_job_id),
      .req_delay        (req_delay),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_job_id   (rsp_out_job_id),
      .rsp_out_due_time (rsp_out_due_time),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_last         (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL sorted_deadline_job_queue");
         $finish;
      end
   end

   // Every so often a side runs a stretch of beats back to back.
   function automatic int draw_wait(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(4, 24);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] job_id,
                               input logic [DELAY_W-1:0] delay, input bit drain);
      int gap;
      gap = draw_wait(send_run);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (drain) begin
         while (scoreboard.pending() != 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_job_id    <= job_id;
      req_delay     <= delay;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scoreboard.apply_request(op, job_id, delay);
   endtask

   initial begin : result_side
      result_beat_type got;
      int              stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(result_run);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.kind      = sdjq_pkg::kind_type'(rsp_kind);
         got.job_id    = rsp_out_job_id;
         got.due       = rsp_out_due_time;
         got.occupancy = rsp_occupancy;
         got.last      = rsp_last;
         scoreboard.check_outcome(got);
      end
   end

   initial begin : stimulus
      logic [OP_W-1:0]    op;
      logic [DELAY_W-1:0] delay;
      int                 sent;
      int                 mode;
      int                 pick;
      int                 insert_edge;
      int                 tick_edge;
      int                 k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, a tick with nothing due and the unused code.
      send_request(sdjq_pkg::OP_POP, 8'h00, 16'h0000, 1'b0);
      send_request(sdjq_pkg::OP_TICK, 8'h00, 16'h0000, 1'b0);
      send_request(sdjq_pkg::OP_NONE, 8'hFF, 16'hFFFF, 1'b0);
      // Due times equal to or earlier than the head go to the front, later ones after their equals.
      send_request(sdjq_pkg::OP_INSERT, 8'h11, 16'd3, 1'b0);
      send_request(sdjq_pkg::OP_INSERT, 8'h22, 16'd3, 1'b0);
      send_request(sdjq_pkg::OP_INSERT, 8'h44, 16'd1, 1'b0);
      send_request(sdjq_pkg::OP_INSERT, 8'h55, 16'd7, 1'b0);
      send_request(sdjq_pkg::OP_INSERT, 8'h66, 16'd7, 1'b0);
      send_request(sdjq_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 1'b0);
      send_request(sdjq_pkg::OP_INSERT, 8'h00, 16'd0, 1'b0);
      send_request(sdjq_pkg::OP_TICK, 8'h00, 16'h0000, 1'b0);
      send_request(sdjq_pkg::OP_POP, 8'h00, 16'h0000, 1'b0);
      send_request(sdjq_pkg::OP_TICK, 8'h00, 16'h0000, 1'b0);
      send_request(sdjq_pkg::OP_TICK, 8'h00, 16'h0000, 1'b0);
      // Fill the queue with far jobs until an insert is turned away.
      for (k = 0; k < DEPTH - 2; k++) begin
         send_request(sdjq_pkg::OP_INSERT, ID_W'($urandom),
                      DELAY_W'($urandom_range(100, 65535)), 1'b0);
      end
      send_request(sdjq_pkg::OP_POP, 8'h00, 16'h0000, 1'b1);

      sent = 0;
      mode = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 30 == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: begin
               insert_edge = 64;
               tick_edge   = 84;
            end
            1: begin
               insert_edge = 40;
               tick_edge   = 94;
            end
            default: begin
               insert_edge = 34;
               tick_edge   = 54;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 4) op = sdjq_pkg::OP_NONE;
         else if (pick < insert_edge) op = sdjq_pkg::OP_INSERT;
         else if (pick < tick_edge) op = sdjq_pkg::OP_TICK;
         else op = sdjq_pkg::OP_POP;
         pick = $urandom_range(0, 19);
         if (pick < 12) delay = DELAY_W'($urandom_range(0, 8));
         else if (pick < 17) delay = DELAY_W'($urandom_range(0, 64));
         else if (pick < 19) delay = DELAY_W'($urandom);
         else delay = '1;
         send_request(op, ID_W'($urandom), delay, $urandom_range(0, 39) == 0);
         if (op != sdjq_pkg::OP_NONE) sent++;
      end

      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("PASS sorted_deadline_job_queue");
      end else begin
         $display("FAIL sorted_deadline_job_queue");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/sdjq_pkg.sv
rtl/sdjq_ctrl.sv
rtl/sdjq_datapath.sv
rtl/sorted_deadline_job_queue.sv
tb/tb_sorted_deadline_job_queue.sv
